### sv/mstsq_pkg.sv
// Package for the music string tone sequencer: codes, note table, widths.
// No dependencies.
package mstsq_pkg;

    localparam int CharW = 8;
    localparam int FreqW = 15;
    localparam int ToneW = 19;
    localparam int GapW  = 17;
    localparam int DivW  = 24;
    localparam int DenW  = 16;

    localparam int DefMaxDigits = 20;
    localparam int DefTopOctave = 6;

    localparam logic [ToneW-1:0] ToneSat = 19'd396000;
    localparam logic [GapW-1:0]  GapSat  = 17'd90000;

    // configuration register indexes
    localparam logic [1:0] CfgLength = 2'd0;
    localparam logic [1:0] CfgTempo  = 2'd1;
    localparam logic [1:0] CfgOctave = 2'd2;
    localparam logic [1:0] CfgMode   = 2'd3;

    // event codes
    localparam logic [1:0] EvTone  = 2'd0;
    localparam logic [1:0] EvPause = 2'd1;
    localparam logic [1:0] EvEnd   = 2'd2;

    // stop causes
    localparam logic [1:0] CauseEnd     = 2'd0;
    localparam logic [1:0] CauseInvalid = 2'd1;
    localparam logic [1:0] CauseAbort   = 2'd2;

    // articulation
    localparam logic [1:0] ModeNormal   = 2'd0;
    localparam logic [1:0] ModeStaccato = 2'd1;
    localparam logic [1:0] ModeLegato   = 2'd2;

    // pending token kinds
    localparam logic [2:0] KNone  = 3'd0;
    localparam logic [2:0] KNote  = 3'd1;
    localparam logic [2:0] KPause = 3'd2;
    localparam logic [2:0] KTempo = 3'd3;
    localparam logic [2:0] KLen   = 3'd4;
    localparam logic [2:0] KOct   = 3'd5;

    // parse phases
    localparam logic [2:0] PhStart  = 3'd0;
    localparam logic [2:0] PhIdle   = 3'd1;
    localparam logic [2:0] PhLetter = 3'd2;
    localparam logic [2:0] PhValue  = 3'd3;
    localparam logic [2:0] PhDigits = 3'd4;
    localparam logic [2:0] PhMode   = 3'd5;

    typedef struct packed {
        logic [1:0]       ev;
        logic [FreqW-1:0] freq;
        logic [ToneW-1:0] tone;
        logic [GapW-1:0]  gap;
        logic [1:0]       cause;
        logic             last;
    } t_result;

    // division request to the serial divider
    typedef struct packed {
        logic            start;
        logic [DivW-1:0] num;
        logic [DenW-1:0] den;
    } t_div_req;

    function automatic logic [FreqW-1:0] note_word(input logic [3:0] idx);
        logic [FreqW-1:0] w;
        begin
            unique case (idx)
                4'd0:    w = 15'd7920;
                4'd1:    w = 15'd8448;
                4'd2:    w = 15'd8800;
                4'd3:    w = 15'd9504;
                4'd4:    w = 15'd10144;
                4'd5:    w = 15'd10560;
                4'd6:    w = 15'd11264;
                4'd7:    w = 15'd11744;
                4'd8:    w = 15'd12672;
                4'd9:    w = 15'd13504;
                4'd10:   w = 15'd14080;
                4'd11:   w = 15'd15200;
                4'd12:   w = 15'd15840;
                4'd13:   w = 15'd16896;
                default: w = '0;
            endcase
            return w;
        end
    endfunction

    function automatic logic [3:0] letter_index(input logic [2:0] l);
        logic [3:0] r;
        begin
            unique case (l)
                3'd0:    r = 4'd10;
                3'd1:    r = 4'd12;
                3'd2:    r = 4'd1;
                3'd3:    r = 4'd3;
                3'd4:    r = 4'd5;
                3'd5:    r = 4'd6;
                3'd6:    r = 4'd8;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### sv/mstsq_if.sv
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing; payload type is a parameter.
interface mstsq_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/mstsq_div.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on mstsq_pkg.
module mstsq_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mstsq_pkg::t_div_req          i_req,
    output logic                         o_busy,
    output logic [mstsq_pkg::DivW-1:0]   o_quot
);
    localparam int CntW = $clog2(mstsq_pkg::DivW + 1);

    logic [mstsq_pkg::DivW-1:0] r_q;
    logic [mstsq_pkg::DenW:0]   r_rem;
    logic [mstsq_pkg::DenW-1:0] r_den;
    logic [CntW-1:0]            r_cnt;
    logic [mstsq_pkg::DenW:0]   n_trial;
    logic [mstsq_pkg::DenW:0]   n_shift;

    // shift in next numerator bit and try the subtract
    always_comb begin
        n_shift = {r_rem[mstsq_pkg::DenW-1:0], r_q[mstsq_pkg::DivW-1]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_q   <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_cnt <= CntW'(mstsq_pkg::DivW);
        end else if (r_cnt != '0) begin
            if (!n_trial[mstsq_pkg::DenW]) begin
                r_rem <= n_trial;
                r_q   <= {r_q[mstsq_pkg::DivW-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_q   <= {r_q[mstsq_pkg::DivW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
endmodule

### sv/music_string_tone_sequencer.sv
// Music-macro string sequencer: parses one byte per beat into tone/pause/end beats.
// A byte with no duration result returns to idle for the next byte, and an end beat is
// loaded after its byte; a note or pause runs a serial tone division, then a gap division
// (each skipped for a zero denominator, the gap one also for a zero gap factor), loads its
// beat and returns to idle; a final byte can run two tokens. A full output register
// stalls beat loading. Synchronous active-low reset restores defaults and start.
module music_string_tone_sequencer #(
    parameter int MAX_DIGITS = mstsq_pkg::DefMaxDigits,
    parameter int TOP_OCTAVE = mstsq_pkg::DefTopOctave
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    mstsq_if.sink      i_in,
    mstsq_if.source    o_out
);
    localparam logic [2:0] TopOct = 3'(TOP_OCTAVE);
    localparam logic [4:0] MaxDig = 5'(MAX_DIGITS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PARSE = 6'b000010,
        S_DIVT  = 6'b000100,
        S_DIVG  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_STOP  = 6'b100000
    } t_state;

    // configuration
    logic [7:0] r_def_len, r_def_tempo;
    logic [2:0] r_def_oct;
    logic [1:0] r_def_mode;

    // parser state
    t_state     r_st;
    logic [2:0] r_phase, r_kind;
    logic [3:0] r_note;
    logic [7:0] r_num, r_tempo, r_len;
    logic [4:0] r_dcnt;
    logic       r_dot, r_stopped;
    logic [2:0] r_oct;
    logic [1:0] r_mode;

    // captured byte
    logic [7:0] r_c;
    logic       r_last, r_ab;
    // end beat queued after a duration beat
    logic       r_end_pend;
    logic [1:0] r_end_cause;
    // string-end pass still to run for the final byte
    logic       r_fin;

    // token under division
    logic [7:0] r_xv;
    logic       r_xdot;
    logic [18:0] r_tone;
    logic [1:0] r_ev;
    logic [14:0] r_freq;
    logic       r_dphase; // 0 launch, 1 waiting

    // output register
    logic               r_ov;
    mstsq_pkg::t_result r_out;

    mstsq_pkg::t_div_req        w_req;
    logic                       w_busy;
    logic [mstsq_pkg::DivW-1:0] w_quot;

    mstsq_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_busy (w_busy),
        .o_quot (w_quot)
    );

    assign i_in.ready  = (r_st == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // mode factors
    logic [4:0] w_ft, w_fg;
    always_comb begin
        unique case (r_mode)
            mstsq_pkg::ModeStaccato: begin w_ft = 5'd15; w_fg = 5'd5; end
            mstsq_pkg::ModeLegato:   begin w_ft = 5'd22; w_fg = 5'd0; end
            default:                 begin w_ft = 5'd18; w_fg = 5'd2; end
        endcase
    end

    // parse one byte: combinational decisions
    logic [7:0] c;
    logic       dig;
    logic [3:0] dv;
    logic       exec, ended, tok_set, mode_set;
    logic [1:0] end_cause, new_mode;
    logic [2:0] nph, nkind;
    logic [3:0] nnote;
    logic [7:0] nnum;
    logic [4:0] ndcnt;
    logic       xdot;
    logic [2:0] nph_after;
    logic       used;
    always_comb begin
        c = (r_c >= 8'h41 && r_c <= 8'h5A) ? r_c + 8'd32 : r_c;
        dig = (c >= 8'h30 && c <= 8'h39);
        dv = c[3:0];
        exec = 1'b0; ended = 1'b0; end_cause = mstsq_pkg::CauseEnd;
        mode_set = 1'b0; new_mode = r_mode;
        nph = r_phase; nkind = r_kind; nnote = r_note; nnum = r_num;
        ndcnt = r_dcnt; xdot = r_dot; used = 1'b0;
        tok_set = 1'b0; nph_after = r_phase;
        if (r_fin) begin
            // string end after the final byte: run the pending token unless a mode letter is pending, then end
            ended = 1'b1;
            if (r_phase == mstsq_pkg::PhMode) begin
                end_cause = mstsq_pkg::CauseInvalid;
            end else begin
                exec = 1'b1; end_cause = mstsq_pkg::CauseEnd;
            end
        end else if (r_ab) begin
            exec = (r_phase != mstsq_pkg::PhMode);
            ended = 1'b1; end_cause = mstsq_pkg::CauseAbort;
        end else begin
            if (r_phase == mstsq_pkg::PhLetter) begin
                if (c == 8'h23 || c == 8'h2B) begin
                    nnote = r_note + 4'd1; nph = mstsq_pkg::PhValue; used = 1'b1;
                end else if (c == 8'h2D) begin
                    nnote = r_note - 4'd1; nph = mstsq_pkg::PhValue; used = 1'b1;
                end
            end
            if (!used && (r_phase == mstsq_pkg::PhLetter || r_phase == mstsq_pkg::PhValue)
                && dig) begin
                nnum = {4'd0, dv}; ndcnt = 5'd1; nph = mstsq_pkg::PhDigits; used = 1'b1;
            end else if (!used && r_phase == mstsq_pkg::PhDigits) begin
                if (dig && r_dcnt < MaxDig) begin
                    nnum = 8'({r_num, 3'b0} + {r_num, 1'b0} + {4'd0, dv});
                    ndcnt = r_dcnt + 5'd1; used = 1'b1;
                end else if (c == 8'h2E) begin
                    xdot = 1'b1; exec = 1'b1; nph = mstsq_pkg::PhIdle; used = 1'b1;
                    tok_set = 1'b1; nkind = mstsq_pkg::KNone;
                end
            end else if (!used && r_phase == mstsq_pkg::PhMode) begin
                if (c == 8'h6E || c == 8'h73 || c == 8'h6C) begin
                    mode_set = 1'b1;
                    new_mode = (c == 8'h6E) ? mstsq_pkg::ModeNormal :
                               (c == 8'h73) ? mstsq_pkg::ModeStaccato :
                                              mstsq_pkg::ModeLegato;
                    nph = mstsq_pkg::PhIdle; used = 1'b1;
                    tok_set = 1'b1; nkind = mstsq_pkg::KNone;
                end else begin
                    ended = 1'b1; end_cause = mstsq_pkg::CauseInvalid;
                end
            end
            if (!used && !ended) begin
                exec = 1'b1; tok_set = 1'b1; nph = mstsq_pkg::PhIdle;
                nkind = mstsq_pkg::KNone;
                if (c >= 8'h61 && c <= 8'h67) begin
                    nkind = mstsq_pkg::KNote;
                    nnote = mstsq_pkg::letter_index(3'(c - 8'h61));
                    nph = mstsq_pkg::PhLetter;
                end else if (c == 8'h70 || c == 8'h74 || c == 8'h6C || c == 8'h6F) begin
                    nkind = (c == 8'h70) ? mstsq_pkg::KPause :
                            (c == 8'h74) ? mstsq_pkg::KTempo :
                            (c == 8'h6C) ? mstsq_pkg::KLen : mstsq_pkg::KOct;
                    nph = mstsq_pkg::PhValue;
                end else if (c == 8'h6D) begin
                    nph = mstsq_pkg::PhMode;
                end else begin
                    ended = 1'b1; end_cause = mstsq_pkg::CauseInvalid;
                end
            end
        end
        nph_after = nph;
    end

    // pending token snapshot for execution
    logic [7:0] xv;
    always_comb begin
        xv = (r_dcnt == 5'd0) ? r_len : r_num;
    end

    // duration denominator
    logic [15:0] den;
    always_comb begin
        den = r_tempo * r_xv;
    end

    // divider request: tone uses ft, gap uses fg, a dot scales by 3/2
    logic [4:0] w_fsel;
    logic [1:0] w_dfac;
    always_comb begin
        w_fsel = (r_st == S_DIVG) ? w_fg : w_ft;
        w_dfac = r_xdot ? 2'd3 : 2'd2;
        w_req.start = ((r_st == S_DIVT) || (r_st == S_DIVG && w_fg != '0))
                      && !r_dphase && den != '0;
        w_req.num   = mstsq_pkg::DivW'(6000) * mstsq_pkg::DivW'(w_dfac)
                      * mstsq_pkg::DivW'(w_fsel);
        w_req.den   = den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_len <= 8'd4; r_def_tempo <= 8'd120; r_def_oct <= 3'd0;
            r_def_mode <= mstsq_pkg::ModeNormal;
            r_st <= S_IDLE; r_phase <= mstsq_pkg::PhStart; r_kind <= mstsq_pkg::KNone;
            r_note <= '0; r_num <= 8'd255; r_dcnt <= '0; r_dot <= 1'b0;
            r_stopped <= 1'b0; r_tempo <= 8'd120; r_len <= 8'd4; r_oct <= '0;
            r_mode <= mstsq_pkg::ModeNormal; r_ov <= 1'b0; r_end_pend <= 1'b0;
            r_fin <= 1'b0; r_dphase <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mstsq_pkg::CfgLength: r_def_len   <= i_cfg_data;
                    mstsq_pkg::CfgTempo:  r_def_tempo <= i_cfg_data;
                    mstsq_pkg::CfgOctave: r_def_oct   <= i_cfg_data[2:0];
                    mstsq_pkg::CfgMode:   r_def_mode  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            // the end beat state reloads the register itself when a beat is taken
            if (o_out.valid && o_out.ready && r_st != S_EMIT) r_ov <= 1'b0;

            unique case (r_st)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_c <= i_in.data.character;
                        r_last <= i_in.data.final_char;
                        r_ab <= i_in.data.abort;
                        if (r_stopped) begin
                            if (i_in.data.final_char) begin
                                r_stopped <= 1'b0; r_phase <= mstsq_pkg::PhStart;
                            end
                        end else begin
                            if (r_phase == mstsq_pkg::PhStart) begin
                                r_len <= r_def_len; r_tempo <= r_def_tempo;
                                r_oct <= (r_def_oct > TopOct) ? TopOct : r_def_oct;
                                r_mode <= r_def_mode;
                                r_kind <= mstsq_pkg::KNone; r_note <= '0;
                                r_num <= 8'd255; r_dcnt <= '0; r_dot <= 1'b0;
                                r_phase <= mstsq_pkg::PhIdle;
                            end
                            r_st <= S_PARSE;
                        end
                    end
                end
                S_PARSE: begin
                    // execute pending token
                    r_end_pend <= ended; r_end_cause <= end_cause;
                    r_fin <= r_last && !ended;
                    r_xv <= xv; r_xdot <= xdot;
                    if (exec) begin
                        unique case (r_kind)
                            mstsq_pkg::KTempo: r_tempo <= r_num;
                            mstsq_pkg::KLen:   r_len <= r_num;
                            mstsq_pkg::KOct:   r_oct <= (r_num > {5'd0, TopOct}) ? TopOct :
                                                         r_num[2:0];
                            default: ;
                        endcase
                    end
                    if (mode_set) r_mode <= new_mode;
                    // next token
                    if (ended) begin
                        r_phase <= mstsq_pkg::PhStart; r_stopped <= !r_last;
                        r_kind <= mstsq_pkg::KNone; r_note <= '0; r_num <= 8'd255;
                        r_dcnt <= '0; r_dot <= 1'b0;
                    end else begin
                        r_phase <= nph_after;
                        if (tok_set || exec) begin
                            r_kind <= nkind; r_note <= nnote; r_num <= 8'd255;
                            r_dcnt <= '0; r_dot <= 1'b0;
                        end else begin
                            r_note <= nnote; r_num <= nnum; r_dcnt <= ndcnt;
                        end
                    end
                    if (exec && (r_kind == mstsq_pkg::KNote || r_kind == mstsq_pkg::KPause)) begin
                        r_ev <= (r_kind == mstsq_pkg::KNote) ? mstsq_pkg::EvTone :
                                                               mstsq_pkg::EvPause;
                        r_freq <= (r_kind == mstsq_pkg::KNote) ?
                                  mstsq_pkg::note_word(r_note) >> (TopOct - r_oct) : '0;
                        r_dphase <= 1'b0; r_tone <= '0;
                        r_st <= S_DIVT;
                    end else begin
                        r_st <= ended ? S_EMIT : (r_last ? S_PARSE : S_IDLE);
                        r_ev <= mstsq_pkg::EvEnd;
                    end
                end
                S_DIVT: begin
                    // tone division
                    if (den == '0) begin
                        r_tone <= mstsq_pkg::ToneSat;
                        r_st <= S_DIVG;
                        r_dphase <= 1'b0;
                    end else if (!r_dphase) begin
                        r_dphase <= 1'b1;
                    end else if (!w_busy) begin
                        r_tone <= (w_quot == '0) ? 19'd1 : w_quot[18:0];
                        r_st <= S_DIVG; r_dphase <= 1'b0;
                    end
                end
                S_DIVG: begin
                    if (den == '0 || w_fg == '0) begin
                        if (!r_ov) begin
                            r_out.ev <= r_ev; r_out.freq <= r_freq; r_out.tone <= r_tone;
                            r_out.gap <= (w_fg == '0) ? '0 : mstsq_pkg::GapSat;
                            r_out.cause <= mstsq_pkg::CauseEnd;
                            r_out.last <= !r_end_pend && !r_fin; r_ov <= 1'b1;
                            r_st <= r_end_pend ? S_EMIT : (r_fin ? S_PARSE : S_IDLE);
                            r_ev <= mstsq_pkg::EvEnd;
                        end
                    end else if (!r_dphase) begin
                        r_dphase <= 1'b1;
                    end else if (!w_busy && !r_ov) begin
                        r_out.ev <= r_ev; r_out.freq <= r_freq; r_out.tone <= r_tone;
                        r_out.gap <= w_quot[16:0];
                        r_out.cause <= mstsq_pkg::CauseEnd;
                        r_out.last <= !r_end_pend && !r_fin; r_ov <= 1'b1;
                        r_st <= r_end_pend ? S_EMIT : (r_fin ? S_PARSE : S_IDLE);
                        r_ev <= mstsq_pkg::EvEnd;
                    end
                end
                S_EMIT: begin
                    if (!r_ov || (o_out.valid && o_out.ready)) begin
                        r_out.ev <= mstsq_pkg::EvEnd; r_out.freq <= '0; r_out.tone <= '0;
                        r_out.gap <= '0; r_out.cause <= r_end_cause; r_out.last <= 1'b1;
                        r_ov <= 1'b1; r_st <= S_IDLE;
                    end
                end
                S_STOP: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule
